@@ src/pffa_pkg.sv @@
// Shared types, codes and constants of the page frame allocator.
package pffa_pkg;

	localparam int MAX_PAGES_DEF  = 4096;
	localparam int MAX_RANGES_DEF = 8;
	localparam int PAGE_BITS_DEF  = 12;

	localparam int ADDR_W  = 52;
	localparam int FRAME_W = 40;
	localparam int INDEX_W = 12;
	localparam int COUNT_W = 13;
	localparam logic [FRAME_W-1:0] KEND_RESET = FRAME_W'(256);

	typedef enum logic [2:0] {
		REQ_ADD    = 3'd0,
		REQ_ALLOC  = 3'd1,
		REQ_FREE   = 3'd2,
		REQ_LOOKUP = 3'd3,
		REQ_QUERY  = 3'd4
	} req_code_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_NO_FREE  = 3'd1,
		STS_DBL_FREE = 3'd2,
		STS_UNMAPPED = 3'd3,
		STS_REJECT   = 3'd4,
		STS_FULL     = 3'd5,
		STS_BAD_IDX  = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		RES_OK,
		RES_NO_FREE,
		RES_DBL_FREE,
		RES_UNMAPPED,
		RES_REJECT,
		RES_FULL,
		RES_BAD_IDX,
		RES_ALLOC,
		RES_FREED,
		RES_QUERY,
		RES_LOOKUP
	} res_kind_t;

	typedef enum logic [1:0] {
		RD_HEAD,
		RD_IDX,
		RD_LKD
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_AR_CHECK,
		S_AR_FIT,
		S_AR_FILL,
		S_ALLOC,
		S_FREE,
		S_QUERY,
		S_LK_RD,
		S_LK_CMP,
		S_LK_CHK,
		S_LK_OUT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [ADDR_W-1:0]  range_base;
		logic [ADDR_W-1:0]  range_length;
		logic [INDEX_W-1:0] descriptor_index;
		logic [ADDR_W-1:0]  phys_address;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [INDEX_W-1:0] page_index;
		logic [FRAME_W-1:0] page_frame;
		logic               page_free;
		logic [COUNT_W-1:0] free_pages;
	} rsp_t;

	typedef struct packed {
		logic      cap;
		logic      ar_align;
		logic      ar_clip;
		logic      ar_commit;
		logic      fill_step;
		logic      desc_rd;
		rd_sel_t   rd_sel;
		logic      alloc_upd;
		logic      free_upd;
		logic      scan_clr;
		logic      rng_rd;
		logic      lk_off;
		logic      set_res;
		res_kind_t res_kind;
		logic      out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] req_code;
		logic       ar_reject;
		logic       ar_full;
		logic       fill_done;
		logic       idx_bad;
		logic       rd_free;
		logic       list_empty;
		logic       scan_end;
		logic       rng_hit;
		logic       d_bad;
		logic       rsp_busy;
	} dp_stat_t;

endpackage

@@ src/pffa_ctrl.sv @@
// Request sequencer of the page frame allocator.
module pffa_ctrl import pffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.req_code)
					REQ_ADD: begin
						cmd.ar_align = 1'b1;
						state_d      = S_AR_CHECK;
					end
					REQ_ALLOC: begin
						if (stat.list_empty) begin
							cmd.set_res  = 1'b1;
							cmd.res_kind = RES_NO_FREE;
							state_d      = S_RESP;
						end else begin
							cmd.desc_rd = 1'b1;
							cmd.rd_sel  = RD_HEAD;
							state_d     = S_ALLOC;
						end
					end
					REQ_FREE, REQ_QUERY: begin
						if (stat.idx_bad) begin
							cmd.set_res  = 1'b1;
							cmd.res_kind = RES_BAD_IDX;
							state_d      = S_RESP;
						end else begin
							cmd.desc_rd = 1'b1;
							cmd.rd_sel  = RD_IDX;
							state_d     = (stat.req_code == REQ_FREE) ? S_FREE : S_QUERY;
						end
					end
					REQ_LOOKUP: begin
						cmd.scan_clr = 1'b1;
						state_d      = S_LK_RD;
					end
					default: begin
						cmd.set_res  = 1'b1;
						cmd.res_kind = RES_OK;
						state_d      = S_RESP;
					end
				endcase
			end
			S_AR_CHECK: begin
				if (stat.ar_reject) begin
					cmd.set_res  = 1'b1;
					cmd.res_kind = RES_REJECT;
					state_d      = S_RESP;
				end else begin
					cmd.ar_clip = 1'b1;
					state_d     = S_AR_FIT;
				end
			end
			S_AR_FIT: begin
				if (stat.ar_full) begin
					cmd.set_res  = 1'b1;
					cmd.res_kind = RES_FULL;
					state_d      = S_RESP;
				end else begin
					cmd.ar_commit = 1'b1;
					state_d       = S_AR_FILL;
				end
			end
			S_AR_FILL: begin
				if (stat.fill_done) begin
					cmd.set_res  = 1'b1;
					cmd.res_kind = RES_OK;
					state_d      = S_RESP;
				end else begin
					cmd.fill_step = 1'b1;
				end
			end
			S_ALLOC: begin
				cmd.alloc_upd = 1'b1;
				cmd.set_res   = 1'b1;
				cmd.res_kind  = RES_ALLOC;
				state_d       = S_RESP;
			end
			S_FREE: begin
				cmd.set_res = 1'b1;
				if (stat.rd_free) begin
					cmd.res_kind = RES_DBL_FREE;
				end else begin
					cmd.free_upd = 1'b1;
					cmd.res_kind = RES_FREED;
				end
				state_d = S_RESP;
			end
			S_QUERY: begin
				cmd.set_res  = 1'b1;
				cmd.res_kind = RES_QUERY;
				state_d      = S_RESP;
			end
			S_LK_RD: begin
				if (stat.scan_end) begin
					cmd.set_res  = 1'b1;
					cmd.res_kind = RES_UNMAPPED;
					state_d      = S_RESP;
				end else begin
					cmd.rng_rd = 1'b1;
					state_d    = S_LK_CMP;
				end
			end
			S_LK_CMP: begin
				// first matching range ends the scan
				if (stat.rng_hit) begin
					cmd.lk_off = 1'b1;
					state_d    = S_LK_CHK;
				end else begin
					state_d = S_LK_RD;
				end
			end
			S_LK_CHK: begin
				if (stat.d_bad) begin
					cmd.set_res  = 1'b1;
					cmd.res_kind = RES_UNMAPPED;
					state_d      = S_RESP;
				end else begin
					cmd.desc_rd = 1'b1;
					cmd.rd_sel  = RD_LKD;
					state_d     = S_LK_OUT;
				end
			end
			S_LK_OUT: begin
				cmd.set_res  = 1'b1;
				cmd.res_kind = RES_LOOKUP;
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (!stat.rsp_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/pffa_dp.sv @@
// Datapath of the page frame allocator: descriptor and range tables, free list, result.
module pffa_dp import pffa_pkg::*; #(
	parameter int MAX_PAGES  = MAX_PAGES_DEF,
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  req_t               req,
	input  logic               cfg_valid,
	input  logic [FRAME_W-1:0] cfg_data,
	input  ctl_cmd_t           cmd,
	output dp_stat_t           stat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp
);

	localparam int IDX_W  = $clog2(MAX_PAGES);
	localparam int CNT_W  = $clog2(MAX_PAGES + 1);
	localparam int RNG_AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int RNG_CW = $clog2(MAX_RANGES + 1);
	localparam int PG_W   = ADDR_W - PAGE_BITS;
	localparam int PGX_W  = PG_W + 1;

	// tables
	logic [FRAME_W-1:0] frame_mem [MAX_PAGES];
	logic               free_mem  [MAX_PAGES];
	logic [CNT_W-1:0]   link_mem  [MAX_PAGES];
	logic [PGX_W-1:0]   rg_first_mem [MAX_RANGES];
	logic [CNT_W-1:0]   rg_cnt_mem   [MAX_RANGES];
	logic [IDX_W-1:0]   rg_desc_mem  [MAX_RANGES];

	logic [FRAME_W-1:0] kend_q;
	logic [CNT_W-1:0]   head_q, count_q, fill_q;
	logic [RNG_CW-1:0]  rfill_q, ptr_q;
	logic               out_valid_q;
	req_t               req_q;
	logic [PGX_W-1:0]   first_q, last_q, n_q, frame_ctr_q;
	logic [CNT_W-1:0]   left_q, d_q;
	logic [FRAME_W-1:0] rd_frame_q;
	logic               rd_free_q;
	logic [CNT_W-1:0]   rd_link_q;
	logic [PGX_W-1:0]   rg_first_q;
	logic [CNT_W-1:0]   rg_cnt_q;
	logic [IDX_W-1:0]   rg_desc_q;
	logic [2:0]         res_status_q;
	logic [INDEX_W-1:0] res_idx_q;
	logic [FRAME_W-1:0] res_frame_q;
	logic               res_free_q;
	rsp_t               rsp_q;

	logic [ADDR_W:0]    sum_first, sum_last;
	logic [63:0]        kend_w, idx_w, pg_w, frame_w, off_w, d_w, head_w, cnt_w;
	logic [PGX_W-1:0]   clip;
	logic [IDX_W-1:0]   idx_a, wa, ra;
	logic [CNT_W-1:0]   idx_c;
	logic               frame_we, free_we, link_we, free_wd;

	assign sum_first = {1'b0, req_q.range_base} + (ADDR_W+1)'((64'd1 << PAGE_BITS) - 64'd1);
	assign sum_last  = {1'b0, req_q.range_base} + {1'b0, req_q.range_length};
	assign kend_w    = 64'(kend_q);
	assign idx_w     = 64'(req_q.descriptor_index);
	assign idx_a     = idx_w[IDX_W-1:0];
	assign idx_c     = idx_w[CNT_W-1:0];
	assign pg_w      = 64'(req_q.phys_address[ADDR_W-1:PAGE_BITS]);
	assign frame_w   = 64'(frame_ctr_q);
	assign off_w     = pg_w - 64'(rg_first_q);
	assign d_w       = 64'(rg_desc_q) + 64'(off_w[CNT_W-1:0]);
	assign head_w    = 64'(head_q);
	assign cnt_w     = 64'(count_q);
	assign clip      = (64'(first_q) < kend_w) ? kend_w[PGX_W-1:0] : first_q;

	always_comb begin
		stat            = '0;
		stat.req_code   = req_q.req_type;
		stat.ar_reject  = (64'(last_q) <= 64'(first_q)) || (64'(last_q) <= kend_w);
		stat.ar_full    = (64'(rfill_q) >= 64'(MAX_RANGES)) ||
			(64'(n_q) > (64'(MAX_PAGES) - 64'(fill_q)));
		stat.fill_done  = (left_q == '0);
		stat.idx_bad    = idx_w >= 64'(fill_q);
		stat.rd_free    = rd_free_q;
		stat.list_empty = (count_q == '0) || (head_w >= 64'(MAX_PAGES));
		stat.scan_end   = ptr_q >= rfill_q;
		stat.rng_hit    = (pg_w >= 64'(rg_first_q)) &&
			(pg_w < (64'(rg_first_q) + 64'(rg_cnt_q)));
		stat.d_bad      = d_q >= fill_q;
		stat.rsp_busy   = out_valid_q && rsp_stall;
	end

	// descriptor write port
	always_comb begin
		wa       = fill_q[IDX_W-1:0];
		frame_we = 1'b0;
		free_we  = 1'b0;
		link_we  = 1'b0;
		free_wd  = 1'b1;
		if (cmd.fill_step) begin
			frame_we = 1'b1;
			free_we  = 1'b1;
			link_we  = 1'b1;
		end else if (cmd.alloc_upd) begin
			wa      = head_q[IDX_W-1:0];
			free_we = 1'b1;
			free_wd = 1'b0;
		end else if (cmd.free_upd) begin
			wa      = idx_a;
			free_we = 1'b1;
			link_we = 1'b1;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_HEAD: ra = head_q[IDX_W-1:0];
			RD_IDX:  ra = idx_a;
			RD_LKD:  ra = d_q[IDX_W-1:0];
			default: ra = idx_a;
		endcase
	end

	always_ff @(posedge clk) begin
		if (frame_we) frame_mem[wa] <= frame_w[FRAME_W-1:0];
		if (free_we)  free_mem[wa]  <= free_wd;
		if (link_we)  link_mem[wa]  <= head_q;
		if (cmd.desc_rd) begin
			rd_frame_q <= frame_mem[ra];
			rd_free_q  <= free_mem[ra];
			rd_link_q  <= link_mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ar_commit) begin
			rg_first_mem[rfill_q[RNG_AW-1:0]] <= first_q;
			rg_cnt_mem[rfill_q[RNG_AW-1:0]]   <= n_q[CNT_W-1:0];
			rg_desc_mem[rfill_q[RNG_AW-1:0]]  <= fill_q[IDX_W-1:0];
		end
		if (cmd.rng_rd) begin
			rg_first_q <= rg_first_mem[ptr_q[RNG_AW-1:0]];
			rg_cnt_q   <= rg_cnt_mem[ptr_q[RNG_AW-1:0]];
			rg_desc_q  <= rg_desc_mem[ptr_q[RNG_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q      <= KEND_RESET;
			head_q      <= CNT_W'(MAX_PAGES);
			count_q     <= '0;
			fill_q      <= '0;
			rfill_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) kend_q <= cfg_data;
			if (cmd.ar_commit) rfill_q <= rfill_q + 1'b1;
			if (cmd.fill_step) begin
				head_q  <= fill_q;
				count_q <= count_q + 1'b1;
				fill_q  <= fill_q + 1'b1;
			end else if (cmd.alloc_upd) begin
				head_q  <= rd_link_q;
				count_q <= count_q - 1'b1;
			end else if (cmd.free_upd) begin
				head_q  <= idx_c;
				count_q <= count_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) req_q <= req;
		if (cmd.ar_align) begin
			first_q <= sum_first[ADDR_W:PAGE_BITS];
			last_q  <= sum_last[ADDR_W:PAGE_BITS];
		end
		if (cmd.ar_clip) begin
			first_q <= clip;
			n_q     <= last_q - clip;
		end
		if (cmd.ar_commit) begin
			frame_ctr_q <= first_q;
			left_q      <= n_q[CNT_W-1:0];
		end else if (cmd.fill_step) begin
			frame_ctr_q <= frame_ctr_q + 1'b1;
			left_q      <= left_q - 1'b1;
		end
		if (cmd.scan_clr) begin
			ptr_q <= '0;
		end else if (cmd.rng_rd) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (cmd.lk_off) d_q <= d_w[CNT_W-1:0];
		if (cmd.set_res) begin
			res_status_q <= STS_OK;
			res_idx_q    <= '0;
			res_frame_q  <= '0;
			res_free_q   <= 1'b0;
			unique case (cmd.res_kind)
				RES_OK:       res_status_q <= STS_OK;
				RES_NO_FREE:  res_status_q <= STS_NO_FREE;
				RES_DBL_FREE: res_status_q <= STS_DBL_FREE;
				RES_UNMAPPED: res_status_q <= STS_UNMAPPED;
				RES_REJECT:   res_status_q <= STS_REJECT;
				RES_FULL:     res_status_q <= STS_FULL;
				RES_BAD_IDX:  res_status_q <= STS_BAD_IDX;
				RES_ALLOC: begin
					res_idx_q   <= head_w[INDEX_W-1:0];
					res_frame_q <= rd_frame_q;
				end
				RES_FREED: begin
					res_idx_q   <= req_q.descriptor_index;
					res_frame_q <= rd_frame_q;
				end
				RES_QUERY: begin
					res_idx_q   <= req_q.descriptor_index;
					res_frame_q <= rd_frame_q;
					res_free_q  <= rd_free_q;
				end
				RES_LOOKUP: begin
					res_idx_q   <= d_q[INDEX_W-1:0];
					res_frame_q <= rd_frame_q;
				end
				default: res_status_q <= STS_OK;
			endcase
		end
		if (cmd.out_load) begin
			rsp_q.status     <= res_status_q;
			rsp_q.page_index <= res_idx_q;
			rsp_q.page_frame <= res_frame_q;
			rsp_q.page_free  <= res_free_q;
			rsp_q.free_pages <= cnt_w[COUNT_W-1:0];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ src/page_frame_free_list_allocator.sv @@
// Page frame free-list allocator: one request in, one result out per transfer.
// Each accepted request returns exactly one result; a new request is taken only once the
// previous one has finished its work, while its result may still wait in the output
// register. Allocate, free and query read the descriptor table through a register between
// the check and the update. Add range writes and pushes one descriptor per cycle for each
// of its n pages on the table's single write port. Lookup examines the ranges in order,
// with a registered range table read and a compare for each, and on a hit reads the
// descriptor if its index lies within the filled table. Unknown request codes answer
// with an OK status. The kernel end register may be written at any idle time;
// no clearing pass is needed after reset.
module page_frame_free_list_allocator import pffa_pkg::*; #(
	parameter int MAX_PAGES  = MAX_PAGES_DEF,
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FRAME_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// kernel end changes only between requests
	assign cfg_ready = ~req_stall;

	pffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pffa_dp #(
		.MAX_PAGES  (MAX_PAGES),
		.MAX_RANGES (MAX_RANGES),
		.PAGE_BITS  (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ src/pffa_check.sv @@
// Port-level checks of the page frame allocator, bound to the top level.
module pffa_check import pffa_pkg::*; #(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STS_OK) |->
			(rsp.page_index == '0) && (rsp.page_frame == '0) && !rsp.page_free)
		else $error("error result carries descriptor data");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.free_pages) <= MAX_PAGES)
		else $error("free page count above table size");

	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !(rsp_valid && rsp_stall && !$past(rsp_valid)))
		else $error("result appeared in the cycle after accept");

endmodule

bind page_frame_free_list_allocator pffa_check #(.MAX_PAGES(MAX_PAGES)) u_pffa_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
